[design/script_token_lexer_defines.svh]
// Assertion macros shared by the lexer RTL.
// Clock and reset are taken from the module that uses the macro.
`ifndef SCRIPT_TOKEN_LEXER_DEFINES_SVH
`define SCRIPT_TOKEN_LEXER_DEFINES_SVH

`ifndef SYNTH

// Checked outside reset
`define STL_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every edge, reset included
`define STL_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`else

`define STL_ASSERT(label, prop, msg)
`define STL_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

[design/stl_pkg.sv]
`default_nettype none

package stl_pkg;

   // Counter and text widths
   localparam int COUNT_W       = 16;
   localparam int KEYWORD_CHARS = 5;
   localparam int PREFIX_W      = 8 * KEYWORD_CHARS;
   localparam int KW_IDX_W      = $clog2(KEYWORD_CHARS);
   localparam int KW_COUNT      = 9;
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
   localparam logic [COUNT_W-1:0] COUNT_ONE = COUNT_W'(1);

   // Token queue
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   // Token kinds
   localparam logic [5:0] KIND_PLUS    = 6'd0;
   localparam logic [5:0] KIND_MINUS   = 6'd1;
   localparam logic [5:0] KIND_PCT     = 6'd2;
   localparam logic [5:0] KIND_GT      = 6'd3;
   localparam logic [5:0] KIND_LT      = 6'd4;
   localparam logic [5:0] KIND_AMP     = 6'd5;
   localparam logic [5:0] KIND_BAR     = 6'd6;
   localparam logic [5:0] KIND_TILDE   = 6'd7;
   localparam logic [5:0] KIND_QMARK   = 6'd8;
   localparam logic [5:0] KIND_BANG    = 6'd9;
   localparam logic [5:0] KIND_LPAR    = 6'd10;
   localparam logic [5:0] KIND_RPAR    = 6'd11;
   localparam logic [5:0] KIND_SEMI    = 6'd12;
   localparam logic [5:0] KIND_SLASH   = 6'd13;
   localparam logic [5:0] KIND_ASSIGN  = 6'd14;
   localparam logic [5:0] KIND_EQ      = 6'd15;
   localparam logic [5:0] KIND_NE      = 6'd16;
   localparam logic [5:0] KIND_GE      = 6'd17;
   localparam logic [5:0] KIND_LE      = 6'd18;
   localparam logic [5:0] KIND_PLUSST  = 6'd19;
   localparam logic [5:0] KIND_MINUSST = 6'd20;
   localparam logic [5:0] KIND_AT      = 6'd21;
   localparam logic [5:0] KIND_BSLASH  = 6'd22;
   localparam logic [5:0] KIND_WRITE   = 6'd23;
   localparam logic [5:0] KIND_NUM     = 6'd24;
   localparam logic [5:0] KIND_RE      = 6'd25;
   localparam logic [5:0] KIND_SUNUM   = 6'd26;
   localparam logic [5:0] KIND_RUN     = 6'd27;
   localparam logic [5:0] KIND_CALL    = 6'd28;
   localparam logic [5:0] KIND_PY      = 6'd29;
   localparam logic [5:0] KIND_FUNC    = 6'd30;
   localparam logic [5:0] KIND_ENDKW   = 6'd31;
   localparam logic [5:0] KIND_IDENT   = 6'd32;
   localparam logic [5:0] KIND_STRING  = 6'd33;
   localparam logic [5:0] KIND_NUMBER  = 6'd34;
   localparam logic [5:0] KIND_COMMENT = 6'd35;
   localparam logic [5:0] KIND_ERROR   = 6'd36;
   localparam logic [5:0] KIND_EOT     = 6'd37;

   // Error causes
   localparam logic [1:0] CAUSE_NONE    = 2'd0;
   localparam logic [1:0] CAUSE_QUOTE   = 2'd1;
   localparam logic [1:0] CAUSE_UNKNOWN = 2'd2;

   // Character codes
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_BANG   = 8'h21;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_PCT    = 8'h25;
   localparam logic [7:0] CH_AMP    = 8'h26;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_LPAR   = 8'h28;
   localparam logic [7:0] CH_RPAR   = 8'h29;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_EQ     = 8'h3D;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_QMARK  = 8'h3F;
   localparam logic [7:0] CH_AT     = 8'h40;
   localparam logic [7:0] CH_UPA    = 8'h41;
   localparam logic [7:0] CH_UPZ    = 8'h5A;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_UNDER  = 8'h5F;
   localparam logic [7:0] CH_LOWA   = 8'h61;
   localparam logic [7:0] CH_LOWZ   = 8'h7A;
   localparam logic [7:0] CH_BAR    = 8'h7C;
   localparam logic [7:0] CH_TILDE  = 8'h7E;

   // Keyword table; text is stored first character in the low byte
   typedef struct packed {
      logic [PREFIX_W-1:0] text;
      logic [3:0]          len;
      logic [5:0]          kind;
   } kw_type;

   localparam kw_type KW_TABLE [KW_COUNT] = '{
      '{PREFIX_W'("etirw"), 4'd5, KIND_WRITE},
      '{PREFIX_W'("mun"),   4'd3, KIND_NUM},
      '{PREFIX_W'("er"),    4'd2, KIND_RE},
      '{PREFIX_W'("munus"), 4'd5, KIND_SUNUM},
      '{PREFIX_W'("nur"),   4'd3, KIND_RUN},
      '{PREFIX_W'("llac"),  4'd4, KIND_CALL},
      '{PREFIX_W'("yp"),    4'd2, KIND_PY},
      '{PREFIX_W'("cnuf"),  4'd4, KIND_FUNC},
      '{PREFIX_W'("dne"),   4'd3, KIND_ENDKW}
   };

   // One result token
   typedef struct packed {
      logic [5:0]         kind;
      logic [1:0]         cause;
      logic [7:0]         bad;
      logic [COUNT_W-1:0] line;
      logic [COUNT_W-1:0] column;
      logic [COUNT_W-1:0] offset;
      logic [COUNT_W-1:0] length;
      logic               last;
   } tok_type;

   // Front to queue: up to two tokens per byte
   typedef struct packed {
      logic    en0;
      logic    en1;
      tok_type tok0;
      tok_type tok1;
   } push_type;

   // Queue to back end
   typedef struct packed {
      logic    nonempty;
      tok_type head;
   } qstat_type;

   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] x);
      return (x == COUNT_MAX) ? x : x + COUNT_ONE;
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= CH_UPA) && (c <= CH_UPZ)) || ((c >= CH_LOWA) && (c <= CH_LOWZ));
   endfunction

   function automatic logic is_word(input logic [7:0] c);
      return is_alpha(c) || ((c >= CH_ZERO) && (c <= CH_NINE)) || (c == CH_UNDER);
   endfunction

   // Characters that may open a two-character operator
   function automatic logic is_op_lead(input logic [7:0] c);
      return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_EQ) ||
             (c == CH_BANG) || (c == CH_GT) || (c == CH_LT);
   endfunction

   // {hit, kind} for a single-character token
   function automatic logic [6:0] single_kind(input logic [7:0] c);
      logic [6:0] r;
      case (c)
         CH_PLUS:   r = {1'b1, KIND_PLUS};
         CH_MINUS:  r = {1'b1, KIND_MINUS};
         CH_PCT:    r = {1'b1, KIND_PCT};
         CH_GT:     r = {1'b1, KIND_GT};
         CH_LT:     r = {1'b1, KIND_LT};
         CH_AMP:    r = {1'b1, KIND_AMP};
         CH_BAR:    r = {1'b1, KIND_BAR};
         CH_TILDE:  r = {1'b1, KIND_TILDE};
         CH_QMARK:  r = {1'b1, KIND_QMARK};
         CH_BANG:   r = {1'b1, KIND_BANG};
         CH_LPAR:   r = {1'b1, KIND_LPAR};
         CH_RPAR:   r = {1'b1, KIND_RPAR};
         CH_SEMI:   r = {1'b1, KIND_SEMI};
         CH_SLASH:  r = {1'b1, KIND_SLASH};
         CH_EQ:     r = {1'b1, KIND_ASSIGN};
         CH_AT:     r = {1'b1, KIND_AT};
         CH_BSLASH: r = {1'b1, KIND_BSLASH};
         default:   r = {1'b0, KIND_PLUS};
      endcase
      return r;
   endfunction

   // Second character that completes a pending operator
   function automatic logic [7:0] second_char(input logic [7:0] lead);
      return ((lead == CH_PLUS) || (lead == CH_MINUS)) ? CH_STAR : CH_EQ;
   endfunction

   function automatic logic [5:0] pair_kind(input logic [7:0] lead);
      logic [5:0] k;
      case (lead)
         CH_PLUS:  k = KIND_PLUSST;
         CH_MINUS: k = KIND_MINUSST;
         CH_EQ:    k = KIND_EQ;
         CH_BANG:  k = KIND_NE;
         CH_GT:    k = KIND_GE;
         default:  k = KIND_LE;
      endcase
      return k;
   endfunction

   // Keyword lookup over the kept prefix; bytes past the word are zero
   function automatic logic [5:0] word_kind(input logic [PREFIX_W-1:0] prefix,
                                            input logic [COUNT_W-1:0]  len);
      logic [5:0] kind;
      kind = KIND_IDENT;
      for (int k = 0; k < KW_COUNT; k++) begin
         if ((len == COUNT_W'(KW_TABLE[k].len)) && (prefix == KW_TABLE[k].text)) begin
            kind = KW_TABLE[k].kind;
         end
      end
      return kind;
   endfunction

   function automatic tok_type make_tok(input logic [5:0]         kind,
                                        input logic [1:0]         cause,
                                        input logic [7:0]         bad,
                                        input logic [COUNT_W-1:0] line,
                                        input logic [COUNT_W-1:0] column,
                                        input logic [COUNT_W-1:0] offset,
                                        input logic [COUNT_W-1:0] length);
      tok_type t;
      t.kind   = kind;
      t.cause  = cause;
      t.bad    = bad;
      t.line   = line;
      t.column = column;
      t.offset = offset;
      t.length = length;
      t.last   = 1'b0;
      return t;
   endfunction

endpackage

`default_nettype wire

[design/stl_req_if.sv]
`default_nettype none

interface stl_req_if
   import stl_pkg::*;
();
   logic       valid;
   logic       ready;
   logic [7:0] char_byte;

   modport source (output valid, output char_byte, input ready);
   modport sink   (input valid, input char_byte, output ready);
endinterface

`default_nettype wire

[design/stl_rsp_if.sv]
`default_nettype none

interface stl_rsp_if
   import stl_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [5:0]         token_kind;
   logic [1:0]         error_cause;
   logic [7:0]         bad_char;
   logic [COUNT_W-1:0] tok_line;
   logic [COUNT_W-1:0] tok_column;
   logic [COUNT_W-1:0] text_offset;
   logic [COUNT_W-1:0] text_length;
   logic               last_of_run;

   modport source (output valid, output token_kind, output error_cause, output bad_char,
                   output tok_line, output tok_column, output text_offset,
                   output text_length, output last_of_run, input ready);
   modport sink   (input valid, input token_kind, input error_cause, input bad_char,
                   input tok_line, input tok_column, input text_offset,
                   input text_length, input last_of_run, output ready);
endinterface

`default_nettype wire

[design/stl_front.sv]
`default_nettype none
`include "script_token_lexer_defines.svh"

module stl_front
   import stl_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   stl_req_if.sink   req_bus,
   input  wire logic q_space,
   output push_type  push
);

   typedef enum logic [5:0] {
      MODE_IDLE    = 6'b000001,
      MODE_WORD    = 6'b000010,
      MODE_QUOTE   = 6'b000100,
      MODE_COMMENT = 6'b001000,
      MODE_OP      = 6'b010000,
      MODE_HALT    = 6'b100000
   } mode_type;

   mode_type            mode_ff, mode_in;
   logic [7:0]          pend_ff, pend_in;
   logic [PREFIX_W-1:0] prefix_ff, prefix_in;
   logic [COUNT_W-1:0]  run_ff, run_in;
   logic [COUNT_W-1:0]  sline_ff, sline_in, scol_ff, scol_in, soff_ff, soff_in;
   logic [COUNT_W-1:0]  cline_ff, cline_in, ccol_ff, ccol_in, coff_ff, coff_in;

   logic [7:0]          c;
   logic                accept;
   logic                run_idle, do_adv, do_mark, restart;
   logic                m_en, i_en;
   tok_type             m_tok, i_tok;
   logic [6:0]          sk;
   logic [6:0]          pk;
   logic [COUNT_W-1:0]  adv_line, adv_col, adv_off;

   assign c               = req_bus.char_byte;
   assign req_bus.ready   = q_space;
   assign accept          = req_bus.valid && q_space;

   // Position after the current byte
   assign adv_line = (c == CH_LF) ? sat_inc(cline_ff) : cline_ff;
   assign adv_col  = (c == CH_LF) ? COUNT_ONE : sat_inc(ccol_ff);
   assign adv_off  = sat_inc(coff_ff);
   assign sk       = single_kind(c);
   assign pk       = single_kind(pend_ff);

   // Byte classification and scanner update
   always_comb begin
      mode_in   = mode_ff;
      pend_in   = pend_ff;
      prefix_in = prefix_ff;
      run_in    = run_ff;
      sline_in  = sline_ff;
      scol_in   = scol_ff;
      soff_in   = soff_ff;
      cline_in  = cline_ff;
      ccol_in   = ccol_ff;
      coff_in   = coff_ff;
      run_idle  = 1'b0;
      do_adv    = 1'b0;
      do_mark   = 1'b0;
      restart   = 1'b0;
      m_en      = 1'b0;
      i_en      = 1'b0;
      m_tok     = '0;
      i_tok     = '0;

      if (accept) begin
         // Token in progress
         case (mode_ff)
            MODE_WORD: begin
               if (is_word(c)) begin
                  if (run_ff < COUNT_W'(KEYWORD_CHARS)) begin
                     prefix_in = prefix_ff |
                                 (PREFIX_W'(c) << {run_ff[KW_IDX_W-1:0], 3'b000});
                  end
                  run_in = sat_inc(run_ff);
                  do_adv = 1'b1;
               end else begin
                  m_en     = 1'b1;
                  m_tok    = make_tok(word_kind(prefix_ff, run_ff), CAUSE_NONE, CH_NUL,
                                      sline_ff, scol_ff, soff_ff, run_ff);
                  mode_in  = MODE_IDLE;
                  run_idle = 1'b1;
               end
            end
            MODE_QUOTE: begin
               if (c == CH_NUL) begin
                  m_en    = 1'b1;
                  m_tok   = make_tok(KIND_ERROR, CAUSE_QUOTE, CH_NUL,
                                     sline_ff, scol_ff, soff_ff, '0);
                  restart = 1'b1;
               end else if (c == pend_ff) begin
                  m_en    = 1'b1;
                  m_tok   = make_tok((c == CH_SQUOTE) ? KIND_NUMBER : KIND_STRING,
                                     CAUSE_NONE, CH_NUL, sline_ff, scol_ff,
                                     sat_inc(soff_ff), run_ff);
                  do_adv  = 1'b1;
                  mode_in = MODE_IDLE;
               end else begin
                  run_in = sat_inc(run_ff);
                  do_adv = 1'b1;
               end
            end
            MODE_COMMENT: begin
               if ((c == CH_NUL) || (c == CH_LF)) begin
                  m_en     = 1'b1;
                  m_tok    = make_tok(KIND_COMMENT, CAUSE_NONE, CH_NUL, sline_ff, scol_ff,
                                      sat_inc(soff_ff), run_ff);
                  mode_in  = MODE_IDLE;
                  run_idle = 1'b1;
               end else begin
                  run_in = sat_inc(run_ff);
                  do_adv = 1'b1;
               end
            end
            MODE_OP: begin
               mode_in = MODE_IDLE;
               m_en    = 1'b1;
               if (c == second_char(pend_ff)) begin
                  m_tok  = make_tok(pair_kind(pend_ff), CAUSE_NONE, CH_NUL,
                                    sline_ff, scol_ff, soff_ff, COUNT_W'(2));
                  do_adv = 1'b1;
               end else begin
                  m_tok    = make_tok(pk[5:0], CAUSE_NONE, CH_NUL,
                                      sline_ff, scol_ff, soff_ff, COUNT_ONE);
                  run_idle = 1'b1;
               end
            end
            MODE_HALT: begin
               if (c == CH_NUL) begin
                  restart = 1'b1;
               end
            end
            default: begin
               run_idle = 1'b1;
            end
         endcase

         // Between tokens: the byte may open a new one
         if (run_idle) begin
            if (c == CH_NUL) begin
               i_en    = 1'b1;
               i_tok   = make_tok(KIND_EOT, CAUSE_NONE, CH_NUL,
                                  cline_ff, ccol_ff, coff_ff, '0);
               restart = 1'b1;
            end else if (is_space(c)) begin
               do_adv = 1'b1;
            end else if (is_alpha(c) || (c == CH_UNDER)) begin
               do_mark   = 1'b1;
               prefix_in = PREFIX_W'(c);
               run_in    = COUNT_ONE;
               do_adv    = 1'b1;
               mode_in   = MODE_WORD;
            end else if ((c == CH_SQUOTE) || (c == CH_DQUOTE)) begin
               do_mark = 1'b1;
               pend_in = c;
               run_in  = '0;
               do_adv  = 1'b1;
               mode_in = MODE_QUOTE;
            end else if (c == CH_HASH) begin
               do_mark = 1'b1;
               run_in  = '0;
               do_adv  = 1'b1;
               mode_in = MODE_COMMENT;
            end else if (is_op_lead(c)) begin
               do_mark = 1'b1;
               pend_in = c;
               do_adv  = 1'b1;
               mode_in = MODE_OP;
            end else if (sk[6]) begin
               i_en   = 1'b1;
               i_tok  = make_tok(sk[5:0], CAUSE_NONE, CH_NUL,
                                 cline_ff, ccol_ff, coff_ff, COUNT_ONE);
               do_adv = 1'b1;
            end else begin
               i_en    = 1'b1;
               i_tok   = make_tok(KIND_ERROR, CAUSE_UNKNOWN, c,
                                  cline_ff, ccol_ff, coff_ff, COUNT_ONE);
               mode_in = MODE_HALT;
            end
         end

         if (do_mark) begin
            sline_in = cline_ff;
            scol_in  = ccol_ff;
            soff_in  = coff_ff;
         end
         if (do_adv) begin
            cline_in = adv_line;
            ccol_in  = adv_col;
            coff_in  = adv_off;
         end
         // End of text: back to line 1, column 1, offset 0
         if (restart) begin
            mode_in   = MODE_IDLE;
            pend_in   = CH_NUL;
            prefix_in = '0;
            run_in    = '0;
            sline_in  = COUNT_ONE;
            scol_in   = COUNT_ONE;
            soff_in   = '0;
            cline_in  = COUNT_ONE;
            ccol_in   = COUNT_ONE;
            coff_in   = '0;
         end
      end
   end

   // Pack tokens in order; the last one carries the run flag
   always_comb begin
      push.en0       = m_en || i_en;
      push.en1       = m_en && i_en;
      push.tok0      = m_en ? m_tok : i_tok;
      push.tok0.last = !(m_en && i_en);
      push.tok1      = i_tok;
      push.tok1.last = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         pend_ff   <= CH_NUL;
         prefix_ff <= '0;
         run_ff    <= '0;
         sline_ff  <= COUNT_ONE;
         scol_ff   <= COUNT_ONE;
         soff_ff   <= '0;
         cline_ff  <= COUNT_ONE;
         ccol_ff   <= COUNT_ONE;
         coff_ff   <= '0;
      end else begin
         mode_ff   <= mode_in;
         pend_ff   <= pend_in;
         prefix_ff <= prefix_in;
         run_ff    <= run_in;
         sline_ff  <= sline_in;
         scol_ff   <= scol_in;
         soff_ff   <= soff_in;
         cline_ff  <= cline_in;
         ccol_ff   <= ccol_in;
         coff_ff   <= coff_in;
      end
   end

   `STL_ASSERT(a_front_pair_order, push.en1 |-> push.en0 && !push.tok0.last, "second token without first")
   `STL_ASSERT(a_front_single_last, (push.en0 && !push.en1) |-> push.tok0.last, "lone token not marked last")
   `STL_ASSERT(a_front_halt_quiet, (accept && (mode_ff == MODE_HALT)) |-> !push.en0, "token emitted after error")
   `STL_ASSERT(a_front_eot_restart, (accept && push.en0 && (push.tok0.kind == KIND_EOT)) |=> (coff_ff == '0) && (cline_ff == COUNT_ONE), "counters not restarted")

endmodule

`default_nettype wire

[design/stl_queue.sv]
`default_nettype none
`include "script_token_lexer_defines.svh"

module stl_queue
   import stl_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire push_type  push,
   output logic           q_space,
   input  wire logic      pop,
   output qstat_type      qstat
);

   tok_type            q_ff [QDEPTH];
   logic [QPTR_W-1:0]  wr_ff, wr_in, rd_ff, rd_in, wr_nx;
   logic [QCNT_W-1:0]  cnt_ff, cnt_in, push_n;

   // Room for the two tokens one byte can make
   assign q_space        = (cnt_ff <= QCNT_W'(QDEPTH - 2));
   assign qstat.nonempty = (cnt_ff != '0);
   assign qstat.head     = q_ff[rd_ff];

   // Pointer and fill update
   always_comb begin
      push_n = QCNT_W'(push.en0) + QCNT_W'(push.en1);
      wr_nx  = wr_ff + QPTR_W'(1);
      wr_in  = wr_ff + QPTR_W'(push_n);
      rd_in  = rd_ff + QPTR_W'(pop);
      cnt_in = cnt_ff + push_n - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Token storage
   always_ff @(posedge clock) begin
      if (push.en0) begin
         q_ff[wr_ff] <= push.tok0;
      end
      if (push.en1) begin
         q_ff[wr_nx] <= push.tok1;
      end
   end

   `STL_ASSERT(a_q_fill_max, cnt_ff <= QCNT_W'(QDEPTH), "queue overfilled")
   `STL_ASSERT(a_q_push_room, push.en0 |-> q_space, "push without room")
   `STL_ASSERT(a_q_pop_data, pop |-> qstat.nonempty, "pop from empty queue")
   `STL_ASSERT_ALWAYS(a_q_reset_empty, reset |=> (cnt_ff == '0), "queue not empty after reset")

endmodule

`default_nettype wire

[design/stl_back.sv]
`default_nettype none
`include "script_token_lexer_defines.svh"

module stl_back
   import stl_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire qstat_type  qstat,
   output logic            pop,
   stl_rsp_if.source       rsp_bus
);

   logic    valid_ff, valid_in, load;
   tok_type tok_ff, tok_in;

   // Output register refills when empty or when its token is taken
   assign load = !valid_ff || rsp_bus.ready;
   assign pop  = load && qstat.nonempty;

   always_comb begin
      valid_in = valid_ff;
      tok_in   = tok_ff;
      if (load) begin
         valid_in = qstat.nonempty;
         tok_in   = qstat.head;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tok_ff <= tok_in;
   end

   assign rsp_bus.valid       = valid_ff;
   assign rsp_bus.token_kind  = tok_ff.kind;
   assign rsp_bus.error_cause = tok_ff.cause;
   assign rsp_bus.bad_char    = tok_ff.bad;
   assign rsp_bus.tok_line    = tok_ff.line;
   assign rsp_bus.tok_column  = tok_ff.column;
   assign rsp_bus.text_offset = tok_ff.offset;
   assign rsp_bus.text_length = tok_ff.length;
   assign rsp_bus.last_of_run = tok_ff.last;

   `STL_ASSERT(a_back_pop_shows, pop |=> valid_ff, "popped token not presented")
   `STL_ASSERT(a_back_no_drop, (valid_ff && !rsp_bus.ready) |-> !pop, "pop while output stalled")
   `STL_ASSERT_ALWAYS(a_back_reset_idle, reset |=> !valid_ff, "output valid after reset")

endmodule

`default_nettype wire

[design/script_token_lexer.sv]
`default_nettype none

// Byte-serial lexer. Source bytes enter on req_bus, one per cycle, and a
// zero byte ends a text. Tokens leave on rsp_bus in source order with kind,
// start line and column, and text offset and length; last_of_run marks the
// final token caused by one byte (a byte can cause two). The front end
// classifies each byte and updates the scanner state in the cycle it is
// accepted, and pushes its tokens into a four-entry queue; the back end
// moves them to a registered output. The input takes a byte every cycle
// while the queue has two free entries, so with rsp_bus.ready held high
// the lexer sustains one byte per cycle; the output drains one token per
// cycle, which sets the rate when bytes produce tokens faster.

module script_token_lexer
   import stl_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   stl_req_if.sink   req_bus,
   stl_rsp_if.source rsp_bus
);

   push_type  push;
   qstat_type qstat;
   logic      q_space;
   logic      pop;

   stl_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .q_space (q_space),
      .push    (push)
   );

   stl_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .q_space (q_space),
      .pop     (pop),
      .qstat   (qstat)
   );

   stl_back u_back (
      .clock   (clock),
      .reset   (reset),
      .qstat   (qstat),
      .pop     (pop),
      .rsp_bus (rsp_bus)
   );

endmodule

`default_nettype wire

[dv/tb_script_token_lexer.sv]
module tb_script_token_lexer;
   timeunit 1ns;
   timeprecision 1ps;
   import stl_pkg::*;

   localparam int LONG_HOLD      = 400;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 20;
   localparam int DIR_ROWS       = 24;

   localparam logic [7:0] OP_SINGLES [11] = '{CH_PCT, CH_AMP, CH_BAR, CH_TILDE, CH_QMARK,
                                              CH_LPAR, CH_RPAR, CH_SEMI, CH_SLASH, CH_AT,
                                              CH_BSLASH};
   localparam logic [7:0] OP_LEADS [6] = '{CH_PLUS, CH_MINUS, CH_EQ, CH_BANG, CH_GT, CH_LT};

   typedef enum logic [5:0] {
      SCAN_IDLE    = 6'b000001,
      SCAN_WORD    = 6'b000010,
      SCAN_QUOTE   = 6'b000100,
      SCAN_COMMENT = 6'b001000,
      SCAN_OP      = 6'b010000,
      SCAN_HALT    = 6'b100000
   } scan_mode_type;

   // One source byte, with a hand-written token where it is obvious
   typedef struct {
      logic [7:0] ch;
      bit         typed;
      tok_type    tok;
   } stim_row_type;

   localparam tok_type NO_TOK = '0;

   logic clock;
   logic reset;

   stl_req_if req_if ();
   stl_rsp_if rsp_if ();

   script_token_lexer DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if)
   );

   // Lexer state tracked on the testbench side
   scan_mode_type       lx_mode;
   logic [7:0]          lx_pend;
   logic [PREFIX_W-1:0] lx_prefix;
   logic [COUNT_W-1:0]  lx_len;
   logic [COUNT_W-1:0]  st_line, st_col, st_off;
   logic [COUNT_W-1:0]  cur_line, cur_col, cur_off;
   tok_type             pred_tok [2];
   int                  pred_n;

   string      kw_text [9] = '{"write", "num", "re", "sunum", "run", "call", "py", "func",
                               "end"};
   logic [5:0] kw_kind [9] = '{KIND_WRITE, KIND_NUM, KIND_RE, KIND_SUNUM, KIND_RUN,
                               KIND_CALL, KIND_PY, KIND_FUNC, KIND_ENDKW};

   stim_row_type feed_q [$];
   tok_type      tokens_due [$];
   stim_row_type dir_table [DIR_ROWS];
   int           items_queued = 0;
   int           items_taken  = 0;
   int           fail_count   = 0;
   int           hold_req     = 0;
   bit           idle_enabled = 1'b1;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic [COUNT_W-1:0] bump(input logic [COUNT_W-1:0] x);
      return (x == COUNT_MAX) ? x : x + 1'b1;
   endfunction

   function automatic bit is_letter(input logic [7:0] c);
      return (c >= CH_UPA && c <= CH_UPZ) || (c >= CH_LOWA && c <= CH_LOWZ);
   endfunction

   // {hit, kind} for bytes that form a token on their own
   function automatic logic [6:0] op_single(input logic [7:0] c);
      case (c)
         CH_PLUS:   return {1'b1, KIND_PLUS};
         CH_MINUS:  return {1'b1, KIND_MINUS};
         CH_PCT:    return {1'b1, KIND_PCT};
         CH_GT:     return {1'b1, KIND_GT};
         CH_LT:     return {1'b1, KIND_LT};
         CH_AMP:    return {1'b1, KIND_AMP};
         CH_BAR:    return {1'b1, KIND_BAR};
         CH_TILDE:  return {1'b1, KIND_TILDE};
         CH_QMARK:  return {1'b1, KIND_QMARK};
         CH_BANG:   return {1'b1, KIND_BANG};
         CH_LPAR:   return {1'b1, KIND_LPAR};
         CH_RPAR:   return {1'b1, KIND_RPAR};
         CH_SEMI:   return {1'b1, KIND_SEMI};
         CH_SLASH:  return {1'b1, KIND_SLASH};
         CH_EQ:     return {1'b1, KIND_ASSIGN};
         CH_AT:     return {1'b1, KIND_AT};
         CH_BSLASH: return {1'b1, KIND_BSLASH};
         default:   return 7'd0;
      endcase
   endfunction

   // Hand-written token, always the last one of its byte
   function automatic tok_type tk(input logic [5:0] kind, input logic [1:0] cause,
                                  input logic [7:0] bad, input logic [15:0] line,
                                  input logic [15:0] col, input logic [15:0] off,
                                  input logic [15:0] len);
      return '{kind, cause, bad, line, col, off, len, 1'b1};
   endfunction

   task automatic restart_text();
      lx_mode   = SCAN_IDLE;
      lx_pend   = '0;
      lx_prefix = '0;
      lx_len    = '0;
      st_line   = 1;
      st_col    = 1;
      st_off    = '0;
      cur_line  = 1;
      cur_col   = 1;
      cur_off   = '0;
   endtask

   task automatic step_pos(input logic [7:0] c);
      if (c == CH_LF) begin
         cur_line = bump(cur_line);
         cur_col  = 1;
      end else begin
         cur_col = bump(cur_col);
      end
      cur_off = bump(cur_off);
   endtask

   task automatic mark_start();
      st_line = cur_line;
      st_col  = cur_col;
      st_off  = cur_off;
   endtask

   task automatic add_tok(input logic [5:0] kind, input logic [1:0] cause,
                          input logic [7:0] bad, input logic [COUNT_W-1:0] line,
                          input logic [COUNT_W-1:0] col, input logic [COUNT_W-1:0] off,
                          input logic [COUNT_W-1:0] len);
      if (pred_n < 2) begin
         pred_tok[pred_n] = '{kind, cause, bad, line, col, off, len, 1'b0};
         pred_n++;
      end
   endtask

   // Byte seen between tokens
   task automatic scan_idle(input logic [7:0] c);
      logic [6:0] single;
      if (c == CH_NUL) begin
         add_tok(KIND_EOT, CAUSE_NONE, 8'h00, cur_line, cur_col, cur_off, '0);
         restart_text();
      end else if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
         step_pos(c);
      end else if (is_letter(c) || c == CH_UNDER) begin
         mark_start();
         lx_prefix      = '0;
         lx_prefix[7:0] = c;
         lx_len         = 1;
         step_pos(c);
         lx_mode = SCAN_WORD;
      end else if (c == CH_SQUOTE || c == CH_DQUOTE) begin
         mark_start();
         lx_pend = c;
         lx_len  = '0;
         step_pos(c);
         lx_mode = SCAN_QUOTE;
      end else if (c == CH_HASH) begin
         mark_start();
         lx_len = '0;
         step_pos(c);
         lx_mode = SCAN_COMMENT;
      end else if (c == CH_PLUS || c == CH_MINUS || c == CH_EQ || c == CH_BANG ||
                   c == CH_GT || c == CH_LT) begin
         mark_start();
         lx_pend = c;
         step_pos(c);
         lx_mode = SCAN_OP;
      end else begin
         single = op_single(c);
         if (single[6]) begin
            add_tok(single[5:0], CAUSE_NONE, 8'h00, cur_line, cur_col, cur_off, 1);
            step_pos(c);
         end else begin
            add_tok(KIND_ERROR, CAUSE_UNKNOWN, c, cur_line, cur_col, cur_off, 1);
            lx_mode = SCAN_HALT;
         end
      end
   endtask

   // Tokens caused by one accepted byte land in pred_tok[0 .. pred_n-1]
   task automatic scan_byte(input logic [7:0] c);
      logic [5:0] kind;
      logic [6:0] single;
      logic [7:0] second;
      bit         same;
      pred_n = 0;
      case (lx_mode)
         SCAN_WORD: begin
            if (is_letter(c) || (c >= CH_ZERO && c <= CH_NINE) || c == CH_UNDER) begin
               if (lx_len < KEYWORD_CHARS) lx_prefix[8*lx_len +: 8] = c;
               lx_len = bump(lx_len);
               step_pos(c);
            end else begin
               // keyword only when the whole word matches
               kind = KIND_IDENT;
               for (int k = 0; k < 9; k++) begin
                  if (lx_len == kw_text[k].len() && kw_text[k].len() <= KEYWORD_CHARS) begin
                     same = 1'b1;
                     for (int i = 0; i < kw_text[k].len(); i++) begin
                        if (lx_prefix[8*i +: 8] != kw_text[k][i]) same = 1'b0;
                     end
                     if (same && kind == KIND_IDENT) kind = kw_kind[k];
                  end
               end
               add_tok(kind, CAUSE_NONE, 8'h00, st_line, st_col, st_off, lx_len);
               lx_mode = SCAN_IDLE;
               scan_idle(c);
            end
         end
         SCAN_QUOTE: begin
            if (c == CH_NUL) begin
               add_tok(KIND_ERROR, CAUSE_QUOTE, 8'h00, st_line, st_col, st_off, '0);
               restart_text();
            end else if (c == lx_pend) begin
               kind = (c == CH_SQUOTE) ? KIND_NUMBER : KIND_STRING;
               add_tok(kind, CAUSE_NONE, 8'h00, st_line, st_col, bump(st_off), lx_len);
               step_pos(c);
               lx_mode = SCAN_IDLE;
            end else begin
               lx_len = bump(lx_len);
               step_pos(c);
            end
         end
         SCAN_COMMENT: begin
            if (c == CH_NUL || c == CH_LF) begin
               add_tok(KIND_COMMENT, CAUSE_NONE, 8'h00, st_line, st_col, bump(st_off), lx_len);
               lx_mode = SCAN_IDLE;
               scan_idle(c);
            end else begin
               lx_len = bump(lx_len);
               step_pos(c);
            end
         end
         SCAN_OP: begin
            second  = (lx_pend == CH_PLUS || lx_pend == CH_MINUS) ? CH_STAR : CH_EQ;
            lx_mode = SCAN_IDLE;
            if (c == second) begin
               case (lx_pend)
                  CH_PLUS:  kind = KIND_PLUSST;
                  CH_MINUS: kind = KIND_MINUSST;
                  CH_EQ:    kind = KIND_EQ;
                  CH_BANG:  kind = KIND_NE;
                  CH_GT:    kind = KIND_GE;
                  default:  kind = KIND_LE;
               endcase
               add_tok(kind, CAUSE_NONE, 8'h00, st_line, st_col, st_off, 2);
               step_pos(c);
            end else begin
               single = op_single(lx_pend);
               add_tok(single[5:0], CAUSE_NONE, 8'h00, st_line, st_col, st_off, 1);
               scan_idle(c);
            end
         end
         SCAN_HALT: begin
            if (c == CH_NUL) restart_text();
         end
         default: scan_idle(c);
      endcase
      if (pred_n > 0) pred_tok[pred_n-1].last = 1'b1;
   endtask

   // Stimulus builders
   task automatic push_byte(input logic [7:0] c);
      feed_q.push_back('{c, 1'b0, NO_TOK});
      items_queued++;
   endtask

   function automatic logic [7:0] rand_word_char();
      int r;
      r = $urandom_range(0, 62);
      if (r < 26) return CH_LOWA + 8'(r);
      if (r < 52) return CH_UPA + 8'(r - 26);
      if (r < 62) return CH_ZERO + 8'(r - 52);
      return CH_UNDER;
   endfunction

   function automatic logic [7:0] rand_other(input logic [7:0] avoid);
      logic [7:0] c;
      do c = 8'($urandom_range(1, 255)); while (c == avoid);
      return c;
   endfunction

   task automatic push_word();
      int         pick, k, n;
      logic [7:0] c;
      pick = $urandom_range(0, 5);
      k    = $urandom_range(0, 8);
      if (pick <= 3) begin
         // keyword, keyword cut short, or keyword with a tail
         n = kw_text[k].len();
         if (pick == 2 && n > 1) n = n - 1;
         for (int i = 0; i < n; i++) push_byte(kw_text[k][i]);
         if (pick == 3) push_byte(rand_word_char());
      end else begin
         do c = rand_word_char(); while (c >= CH_ZERO && c <= CH_NINE);
         push_byte(c);
         repeat ($urandom_range(0, 7)) push_byte(rand_word_char());
      end
   endtask

   task automatic push_quoted(input logic [7:0] q, input bit closed);
      push_byte(q);
      repeat ($urandom_range(0, 6)) push_byte(rand_other(q));
      if (closed) push_byte(q);
   endtask

   task automatic push_comment(input bit closed);
      push_byte(CH_HASH);
      repeat ($urandom_range(0, 8)) push_byte(rand_other(CH_LF));
      if (closed) push_byte(CH_LF);
   endtask

   // One text: mostly well-formed tokens, a little noise, then the zero byte
   task automatic gen_text();
      logic [7:0] lead;
      int         ws;
      repeat ($urandom_range(1, 12)) begin
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5: push_word();
            6, 7, 8: push_byte(OP_SINGLES[$urandom_range(0, 10)]);
            9, 10: begin
               lead = OP_LEADS[$urandom_range(0, 5)];
               push_byte(lead);
               if ($urandom_range(0, 1)) begin
                  push_byte((lead == CH_PLUS || lead == CH_MINUS) ? CH_STAR : CH_EQ);
               end
            end
            11: push_quoted(CH_DQUOTE, 1'b1);
            12: push_quoted(CH_SQUOTE, 1'b1);
            13: push_comment(1'b1);
            18: push_byte(8'($urandom_range(1, 255)));
            default: begin
               repeat ($urandom_range(1, 3)) begin
                  ws = $urandom_range(0, 5);
                  push_byte((ws == 5) ? CH_SPACE : CH_TAB + 8'(ws));
               end
            end
         endcase
      end
      // text sometimes ending inside a token
      case ($urandom_range(0, 9))
         0: push_comment(1'b0);
         1: push_quoted($urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE, 1'b0);
         2: push_byte(OP_LEADS[$urandom_range(0, 5)]);
         3: push_word();
         default: ;
      endcase
      push_byte(CH_NUL);
   endtask

   task automatic wait_settled();
      while (!(items_taken == items_queued && tokens_due.size() == 0)) @(posedge clock);
   endtask

   task automatic note_fail(input string msg);
      fail_count++;
      if (fail_count <= 10) $display("%s", msg);
   endtask

   // Byte sender
   initial begin
      stim_row_type cur_row;
      bit           took;
      int           gap_left;
      req_if.valid     = 1'b0;
      req_if.char_byte = '0;
      gap_left         = 0;
      restart_text();
      forever begin
         @(posedge clock);
         if (reset) begin
            req_if.valid <= 1'b0;
         end else begin
            took = req_if.valid && req_if.ready;
            if (took) begin
               scan_byte(cur_row.ch);
               if (cur_row.typed) begin
                  tokens_due.push_back(cur_row.tok);
               end else begin
                  for (int i = 0; i < pred_n; i++) tokens_due.push_back(pred_tok[i]);
               end
               items_taken++;
            end
            if (req_if.valid && !took) begin
               // hold the offered byte
            end else if (gap_left > 0) begin
               gap_left--;
               req_if.valid <= 1'b0;
            end else if (idle_enabled && $urandom_range(0, 11) == 0) begin
               gap_left = $urandom_range(1, 14) - 1;
               req_if.valid <= 1'b0;
            end else if (feed_q.size() > 0) begin
               cur_row = feed_q.pop_front();
               req_if.valid     <= 1'b1;
               req_if.char_byte <= cur_row.ch;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // Token receiver and checker
   initial begin
      tok_type got, want;
      int      hold_seen, hold_left, stall_left;
      rsp_if.ready = 1'b0;
      hold_seen    = 0;
      hold_left    = 0;
      stall_left   = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) begin
            got = '{rsp_if.token_kind, rsp_if.error_cause, rsp_if.bad_char, rsp_if.tok_line,
                    rsp_if.tok_column, rsp_if.text_offset, rsp_if.text_length,
                    rsp_if.last_of_run};
            if (tokens_due.size() == 0) begin
               note_fail($sformatf("unexpected token: kind %0d line %0d col %0d off %0d",
                                   got.kind, got.line, got.column, got.offset));
            end else begin
               want = tokens_due.pop_front();
               if (got.kind !== want.kind || got.cause !== want.cause ||
                   got.bad !== want.bad || got.line !== want.line ||
                   got.column !== want.column || got.offset !== want.offset ||
                   got.length !== want.length || got.last !== want.last) begin
                  note_fail($sformatf({"token mismatch: expected kind %0d cause %0d bad %02h ",
                                       "line %0d col %0d off %0d len %0d last %0d, got kind %0d ",
                                       "cause %0d bad %02h line %0d col %0d off %0d len %0d ",
                                       "last %0d"},
                                      want.kind, want.cause, want.bad, want.line, want.column,
                                      want.offset, want.length, want.last, got.kind, got.cause,
                                      got.bad, got.line, got.column, got.offset, got.length,
                                      got.last));
               end
            end
         end
         if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = LONG_HOLD;
         end
         if (reset) begin
            rsp_if.ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else if (idle_enabled && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 14) - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // Watchdog on cycles with no transaction on either side
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) quiet = 0;
         else quiet++;
      end
      $display("script_token_lexer regression: fail");
      $finish;
   end

   // Test sequence
   initial begin
      int base;
      reset = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: positions after reset, errors, quote left open, operators
      dir_table = '{
         '{CH_PCT,    1'b1, tk(KIND_PCT,     CAUSE_NONE,    8'h00, 1, 1, 0, 1)},
         '{CH_AT,     1'b1, tk(KIND_AT,      CAUSE_NONE,    8'h00, 1, 2, 1, 1)},
         '{CH_BSLASH, 1'b1, tk(KIND_BSLASH,  CAUSE_NONE,    8'h00, 1, 3, 2, 1)},
         '{CH_NUL,    1'b1, tk(KIND_EOT,     CAUSE_NONE,    8'h00, 1, 4, 3, 0)},
         '{8'hFF,     1'b1, tk(KIND_ERROR,   CAUSE_UNKNOWN, 8'hFF, 1, 1, 0, 1)},
         '{CH_LOWA,   1'b0, NO_TOK},
         '{CH_NUL,    1'b0, NO_TOK},
         '{CH_NUL,    1'b1, tk(KIND_EOT,     CAUSE_NONE,    8'h00, 1, 1, 0, 0)},
         '{CH_DQUOTE, 1'b0, NO_TOK},
         '{CH_LF,     1'b0, NO_TOK},
         '{CH_NUL,    1'b1, tk(KIND_ERROR,   CAUSE_QUOTE,   8'h00, 1, 1, 0, 0)},
         '{8'h80,     1'b1, tk(KIND_ERROR,   CAUSE_UNKNOWN, 8'h80, 1, 1, 0, 1)},
         '{CH_NUL,    1'b0, NO_TOK},
         '{8'h72,     1'b0, NO_TOK},   // r
         '{8'h65,     1'b0, NO_TOK},   // e
         '{CH_PLUS,   1'b1, tk(KIND_RE,      CAUSE_NONE,    8'h00, 1, 1, 0, 2)},
         '{CH_STAR,   1'b1, tk(KIND_PLUSST,  CAUSE_NONE,    8'h00, 1, 3, 2, 2)},
         '{CH_SQUOTE, 1'b0, NO_TOK},
         '{8'h37,     1'b0, NO_TOK},   // 7
         '{CH_SQUOTE, 1'b1, tk(KIND_NUMBER,  CAUSE_NONE,    8'h00, 1, 5, 5, 1)},
         '{CH_HASH,   1'b0, NO_TOK},
         '{8'h71,     1'b0, NO_TOK},   // q
         '{CH_LF,     1'b1, tk(KIND_COMMENT, CAUSE_NONE,    8'h00, 1, 8, 8, 1)},
         '{CH_NUL,    1'b1, tk(KIND_EOT,     CAUSE_NONE,    8'h00, 2, 1, 10, 0)}
      };
      foreach (dir_table[i]) begin
         feed_q.push_back(dir_table[i]);
         items_queued++;
      end
      wait_settled();

      // Receiver holds off while single-byte tokens keep coming
      hold_req++;
      repeat (40) push_byte(OP_SINGLES[$urandom_range(0, 10)]);
      push_byte(CH_NUL);
      wait_settled();

      // Random texts with idling on both sides
      base = items_queued;
      while (items_queued - base < 1100) gen_text();
      wait_settled();

      // Closing stretch at full rate
      idle_enabled = 1'b0;
      base = items_queued;
      while (items_queued - base < 200) gen_text();
      wait_settled();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tokens_due.size() != 0) begin
         note_fail($sformatf("%0d expected tokens never arrived", tokens_due.size()));
      end
      if (fail_count == 0) begin
         $display("script_token_lexer regression: pass");
      end else begin
         $display("script_token_lexer regression: fail");
      end
      $finish;
   end

endmodule

[script_token_lexer.f]
+incdir+design
design/stl_pkg.sv
design/stl_req_if.sv
design/stl_rsp_if.sv
design/stl_front.sv
design/stl_queue.sv
design/stl_back.sv
design/script_token_lexer.sv
dv/tb_script_token_lexer.sv
